[rtl/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// Beat types, CORDIC arctangent table and fixed constants of the compass.
// ----------------------------------------------------------------------------
package tcc_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic               button_pressed;
  } sample_t;

  typedef struct packed {
    logic signed [12:0] heading_angle;
    logic signed [11:0] pitch_angle;
    logic signed [11:0] roll_angle;
    logic [2:0]         led_index;
    logic               led_enable;
    logic               display_mode;
  } result_t;

  // binary angle: full turn is 2^32
  localparam logic signed [33:0] HALF_TURN  = 34'sh0_8000_0000;
  localparam logic signed [39:0] COS_START  = 40'sd652032874;
  localparam logic [31:0]        DEG16_TURN = 32'd5760;   // 1/16 degree per turn
  localparam logic signed [13:0] DEG16_HALF = 14'sd2880;
  localparam logic signed [13:0] DEG16_QTR  = 14'sd1440;
  localparam logic [5:0]         ROOT_STEPS = 6'd17;      // 34-bit radicand, 2 bits a step
  localparam logic [5:0]         SENS_MUL_N = 6'd17;      // sensor word as multiplier
  localparam logic [5:0]         TRIG_MUL_N = 6'd32;      // Q30 word as multiplier
  localparam logic [5:0]         DEG_MUL_N  = 6'd14;      // 5760 as multiplier

  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/tilt_compensated_compass.sv]
// ----------------------------------------------------------------------------
// tilt_compensated_compass
// Pitch, roll and tilt compensated heading from one accel/mag sample beat.
// ----------------------------------------------------------------------------
// One sample beat at a time. The time from accept to result is set by the
// serial multiply-accumulate, which retires one multiplier bit per cycle over
// nine 17-bit, two 32-bit and three 14-bit products, by the square root,
// which yields one root bit per cycle, and by the shared CORDIC stage, which
// runs one iteration per cycle for five arctangent / sine-cosine passes. The
// input is stalled while an item is in work; a finished result sits in the
// output register, so the next sample is taken while it waits to be read.
// Angles are in 1/16 degree; atan2(0,0) reads as zero.
// ----------------------------------------------------------------------------
module tilt_compensated_compass #(
  parameter int CORDIC_ITERATIONS = 16,   // 8..24
  parameter int SENSOR_BITS       = 16    // 8..32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  tcc_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output tcc_pkg::result_t result
);
  import tcc_pkg::*;

  // sequencer program counter: idle, one entry per arithmetic pass, output
  localparam logic [4:0] PC_IDLE   = 5'd0;
  localparam logic [4:0] PC_SQ_AY  = 5'd1;
  localparam logic [4:0] PC_SQ_AZ  = 5'd2;
  localparam logic [4:0] PC_ROOT_P = 5'd3;
  localparam logic [4:0] PC_SQ_AX  = 5'd4;
  localparam logic [4:0] PC_SQ_AZ2 = 5'd5;
  localparam logic [4:0] PC_ROOT_R = 5'd6;
  localparam logic [4:0] PC_VEC_P  = 5'd7;
  localparam logic [4:0] PC_VEC_R  = 5'd8;
  localparam logic [4:0] PC_ROT_P  = 5'd9;
  localparam logic [4:0] PC_ROT_R  = 5'd10;
  localparam logic [4:0] PC_SRSP   = 5'd11;
  localparam logic [4:0] PC_SRCP   = 5'd12;
  localparam logic [4:0] PC_XH_A   = 5'd13;
  localparam logic [4:0] PC_XH_B   = 5'd14;
  localparam logic [4:0] PC_YH_A   = 5'd15;
  localparam logic [4:0] PC_YH_B   = 5'd16;
  localparam logic [4:0] PC_YH_C   = 5'd17;
  localparam logic [4:0] PC_VEC_H  = 5'd18;
  localparam logic [4:0] PC_CV_H   = 5'd19;
  localparam logic [4:0] PC_CV_P   = 5'd20;
  localparam logic [4:0] PC_CV_R   = 5'd21;
  localparam logic [4:0] PC_OUT    = 5'd22;

  // accumulator preset for a MAC pass
  localparam logic [1:0] ACC_KEEP  = 2'd0;
  localparam logic [1:0] ACC_CLR   = 2'd1;
  localparam logic [1:0] ACC_ROUND = 2'd2;

  localparam logic [5:0] NITER  = 6'(CORDIC_ITERATIONS);
  localparam int         SB_TOP = (SENSOR_BITS > 16) ? 15 : SENSOR_BITS - 1;

  // Sensor word: low SENSOR_BITS bits, sign extended. Above 16 bits the
  // field arrives zero extended.
  function automatic logic signed [16:0] sens(input logic [15:0] raw);
    logic signed [16:0] v;
    for (int k = 0; k < 17; k++) begin
      if (k < SENSOR_BITS) v[k] = (k < 16) ? raw[4'(k)] : 1'b0;
      else                 v[k] = raw[SB_TOP];
    end
    return v;
  endfunction

  // clamp a binary angle to a half turn and offset it to [0, 2^32]
  function automatic logic [32:0] ang_off(input logic signed [33:0] a);
    logic signed [33:0] s;
    s = a + HALF_TURN;
    if (a < -HALF_TURN)     return 33'd0;
    else if (a > HALF_TURN) return 33'h1_0000_0000;
    else                    return s[32:0];
  endfunction

  // sequencer
  logic [4:0] pc;
  logic       run;
  logic [5:0] cnt;
  logic       mode_bit;

  // serial multiply-accumulate: one multiplier bit a cycle
  logic signed [63:0] mac_a;
  logic [31:0]        mac_b;
  logic signed [63:0] acc;

  // square root: two radicand bits a cycle
  logic [33:0] rad;
  logic [19:0] rem;
  logic [16:0] rt;

  // shared CORDIC stage
  logic signed [39:0] cx, cy;
  logic signed [33:0] cz;
  logic               vzero;

  // held sample and intermediates
  logic signed [16:0] ax, ay, az, mx, my, mz;
  logic [16:0]        rp, rr;
  logic signed [33:0] pa, ra, ha;
  logic signed [31:0] cp, sp, cr, sr, srsp, srcp;
  logic signed [39:0] xh, yh;
  logic signed [12:0] h16;
  logic signed [11:0] p16, r16;

  // pass decode
  logic is_mac, is_root, is_vec, is_rot;
  logic signed [63:0] op_a;
  logic [31:0]        op_b;
  logic [5:0]         op_n;
  logic [1:0]         op_acc;
  logic signed [39:0] vx, vy;
  logic [32:0]        off;

  always_comb begin
    is_mac  = 1'b0;
    is_root = 1'b0;
    is_vec  = 1'b0;
    is_rot  = 1'b0;
    op_a    = '0;
    op_b    = '0;
    op_n    = SENS_MUL_N;
    op_acc  = ACC_KEEP;
    vx      = '0;
    vy      = '0;
    off     = '0;
    unique case (pc)
      PC_SQ_AY: begin
        is_mac = 1'b1; op_a = 64'(ay); op_b = 32'(ay); op_acc = ACC_CLR;
      end
      PC_SQ_AZ, PC_SQ_AZ2: begin
        is_mac = 1'b1; op_a = 64'(az); op_b = 32'(az);
      end
      PC_SQ_AX: begin
        is_mac = 1'b1; op_a = 64'(ax); op_b = 32'(ax); op_acc = ACC_CLR;
      end
      PC_ROOT_P, PC_ROOT_R: is_root = 1'b1;
      PC_VEC_P: begin
        is_vec = 1'b1; vx = 40'({rp, 16'd0}); vy = 40'(ax) <<< 16;
      end
      PC_VEC_R: begin
        is_vec = 1'b1; vx = 40'({rr, 16'd0}); vy = 40'(ay) <<< 16;
      end
      PC_VEC_H: begin
        is_vec = 1'b1; vx = xh; vy = yh;
      end
      PC_ROT_P, PC_ROT_R: is_rot = 1'b1;
      PC_SRSP: begin
        is_mac = 1'b1; op_a = 64'(sp); op_b = sr; op_n = TRIG_MUL_N; op_acc = ACC_CLR;
      end
      PC_SRCP: begin
        is_mac = 1'b1; op_a = 64'(cp); op_b = sr; op_n = TRIG_MUL_N; op_acc = ACC_CLR;
      end
      PC_XH_A: begin
        is_mac = 1'b1; op_a = 64'(cp); op_b = 32'(mx); op_acc = ACC_CLR;
      end
      PC_XH_B: begin
        is_mac = 1'b1; op_a = 64'(sp); op_b = 32'(mz);
      end
      PC_YH_A: begin
        is_mac = 1'b1; op_a = 64'(srsp); op_b = 32'(mx); op_acc = ACC_CLR;
      end
      PC_YH_B: begin
        is_mac = 1'b1; op_a = 64'(cr); op_b = 32'(my);
      end
      PC_YH_C: begin
        is_mac = 1'b1; op_a = -64'(srcp); op_b = 32'(mz);
      end
      PC_CV_H, PC_CV_P, PC_CV_R: begin
        is_mac = 1'b1;
        if (pc == PC_CV_H)      off = ang_off(ha);
        else if (pc == PC_CV_P) off = ang_off(pa);
        else                    off = ang_off(ra);
        op_a   = signed'(64'(off));
        op_b   = DEG16_TURN;
        op_n   = DEG_MUL_N;
        op_acc = ACC_ROUND;
      end
      default: ;
    endcase
  end

  // one CORDIC iteration; 'up' rotates toward positive angle accumulation
  logic [4:0]         idx;
  logic signed [39:0] xs, ys;
  logic signed [33:0] at;
  logic               up;

  always_comb begin
    idx = 5'(NITER - cnt);
    xs  = cx >>> idx;
    ys  = cy >>> idx;
    at  = 34'(atan_entry(idx));
    up  = is_vec ? (cy > 0) : (cz < 0);
  end

  // root step
  logic [21:0] rsh, rtrial;
  always_comb begin
    rsh    = {rem, rad[33:32]};
    rtrial = {3'd0, rt, 2'b01};
  end

  // 1/16 degree from the rounded product, with range clamp
  logic signed [13:0] deg;
  logic signed [13:0] deg_q;
  always_comb begin
    deg   = signed'({1'b0, acc[44:32]}) - DEG16_HALF;
    deg_q = deg;
    if (deg > DEG16_QTR)  deg_q = DEG16_QTR;
    if (deg < -DEG16_QTR) deg_q = -DEG16_QTR;
  end

  // octant: round |heading|/45 deg half up to n, then (8 - n) mod 8 for a positive heading, n for a negative one
  logic [12:0] hmag;
  logic [2:0]  oct;
  logic [2:0]  led;
  always_comb begin
    hmag = h16[12] ? 13'(-h16) : 13'(h16);
    oct  = 3'(hmag >= 13'd360) + 3'(hmag >= 13'd1080)
         + 3'(hmag >= 13'd1800) + 3'(hmag >= 13'd2520);
    led  = h16[12] ? oct : 3'(-oct);
  end

  assign sample_stall = rst || (pc != PC_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= PC_IDLE;
      run          <= 1'b0;
      cnt          <= '0;
      mode_bit     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // the output step reloads the register itself
      if (result_valid && !result_stall && pc != PC_OUT) result_valid <= 1'b0;

      priority if (pc == PC_IDLE) begin
        if (sample_valid) begin
          ax       <= sens(sample.accel_x);
          ay       <= sens(sample.accel_y);
          az       <= sens(sample.accel_z);
          mx       <= sens(sample.mag_x);
          my       <= sens(sample.mag_y);
          mz       <= sens(sample.mag_z);
          mode_bit <= mode_bit ^ sample.button_pressed;
          pc       <= PC_SQ_AY;
        end
      end else if (pc == PC_OUT) begin
        // hand off to the output register; a waiting beat must drain first
        if (!result_valid || !result_stall) begin
          result.heading_angle <= h16;
          result.pitch_angle   <= p16;
          result.roll_angle    <= r16;
          result.led_index     <= mode_bit ? 3'd0 : led;
          result.led_enable    <= !mode_bit;
          result.display_mode  <= mode_bit;
          result_valid         <= 1'b1;
          pc                   <= PC_IDLE;
        end
      end else if (!run) begin
        // launch a pass
        run <= 1'b1;
        if (is_mac) begin
          mac_a <= op_a;
          mac_b <= op_b;
          cnt   <= op_n;
          if (op_acc == ACC_CLR)        acc <= '0;
          else if (op_acc == ACC_ROUND) acc <= 64'sh8000_0000;
        end
        if (is_root) begin
          rad <= acc[33:0];
          rem <= '0;
          rt  <= '0;
          cnt <= ROOT_STEPS;
        end
        if (is_vec) begin
          vzero <= (vx == 0) && (vy == 0);
          cnt   <= NITER;
          if (vx < 0) begin
            cz <= (vy >= 0) ? HALF_TURN : -HALF_TURN;
            cx <= -vx;
            cy <= -vy;
          end else begin
            cz <= '0;
            cx <= vx;
            cy <= vy;
          end
        end
        if (is_rot) begin
          cx  <= COS_START;
          cy  <= '0;
          cz  <= (pc == PC_ROT_P) ? pa : ra;
          cnt <= NITER;
        end
      end else if (cnt != 6'd0) begin
        cnt <= cnt - 6'd1;
        if (is_mac) begin
          // multiplier MSB carries negative weight
          if (mac_b[0]) acc <= (cnt == 6'd1) ? acc - mac_a : acc + mac_a;
          mac_a <= mac_a <<< 1;
          mac_b <= mac_b >> 1;
        end
        if (is_root) begin
          rad <= rad << 2;
          if (rsh >= rtrial) begin
            rem <= 20'(rsh - rtrial);
            rt  <= {rt[15:0], 1'b1};
          end else begin
            rem <= rsh[19:0];
            rt  <= {rt[15:0], 1'b0};
          end
        end
        if (is_vec || is_rot) begin
          if (up) begin
            cx <= cx + ys;
            cy <= cy - xs;
            cz <= cz + at;
          end else begin
            cx <= cx - ys;
            cy <= cy + xs;
            cz <= cz - at;
          end
        end
      end else begin
        // store the pass result and move on
        run <= 1'b0;
        pc  <= pc + 5'd1;
        unique case (pc)
          PC_ROOT_P: rp   <= rt;
          PC_ROOT_R: rr   <= rt;
          PC_VEC_P:  pa   <= vzero ? '0 : cz;
          PC_VEC_R:  ra   <= vzero ? '0 : cz;
          PC_VEC_H:  ha   <= vzero ? '0 : cz;
          PC_ROT_P: begin
            cp <= cx[31:0];
            sp <= cy[31:0];
          end
          PC_ROT_R: begin
            cr <= cx[31:0];
            sr <= cy[31:0];
          end
          PC_SRSP:   srsp <= 32'(acc >>> 30);
          PC_SRCP:   srcp <= 32'(acc >>> 30);
          PC_XH_B:   xh   <= 40'(acc >>> 14);
          PC_YH_C:   yh   <= 40'(acc >>> 14);
          PC_CV_H:   h16  <= 13'(deg);
          PC_CV_P:   p16  <= 12'(deg_q);
          PC_CV_R:   r16  <= 12'(deg_q);
          default: ;
        endcase
      end
    end
  end

  // an accepted sample always starts the program at its first pass
  a_start: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> (pc == PC_SQ_AY && !run))
    else $error("sample accept did not start the sequencer");

  // a new result beat comes only from the output step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(pc) == PC_OUT)
    else $error("result raised outside the output step");

  // the mode bit moves only on a sample beat with the button set
  a_mode: assert property (@(posedge clk) disable iff (rst)
    !(sample_valid && !sample_stall && sample.button_pressed) |=> $stable(mode_bit))
    else $error("mode bit changed without a button beat");

  // pass counter stays within the longest pass
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    run |-> cnt <= TRIG_MUL_N)
    else $error("pass counter out of range");

endmodule

[tb/tilt_compensated_compass_test.sv]
// ----------------------------------------------------------------------------
// tilt_compensated_compass_test
// Sends accel/mag sample beats through the compass and checks every result
// beat against a bit-exact fixed-point predictor kept in this bench.
// ----------------------------------------------------------------------------
module tilt_compensated_compass_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcc_pkg::*;

  localparam int ITERS = 16;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    sample_valid = 1'b0;
  logic    sample_stall;
  sample_t sample = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  tilt_compensated_compass dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state and expected result beats
  logic    heading_mode_bit;
  result_t expected_q[$];
  int      mismatches = 0;
  int      beats_sent = 0;
  int      beats_checked = 0;
  bit      no_idle = 1'b0;   // long stretch with no gaps on either side
  int      press_count = 0;

  function automatic longint fshr(longint v, int s);
    return v >>> s;   // arithmetic shift on signed longint is a floor
  endfunction

  function automatic longint atan_step(int i);
    longint t [24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  function automatic longint isqrt(longint n);
    longint res = 0;
    longint b = 64'sh4000_0000_0000_0000;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // vectoring CORDIC: binary angle of (x, y), full turn 2^32
  function automatic longint bin_atan2(longint x, longint y);
    longint z = 0;
    longint nx, ny;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < ITERS; i++) begin
      if (y > 0) begin
        nx = x + fshr(y, i); ny = y - fshr(x, i); z += atan_step(i);
      end else begin
        nx = x - fshr(y, i); ny = y + fshr(x, i); z -= atan_step(i);
      end
      x = nx; y = ny;
    end
    return z;
  endfunction

  task automatic rot_sincos(input longint z, output longint c, output longint s);
    longint x = 652032874;
    longint y = 0;
    longint nx, ny;
    for (int i = 0; i < ITERS; i++) begin
      if (z >= 0) begin
        nx = x - fshr(y, i); ny = y + fshr(x, i); z -= atan_step(i);
      end else begin
        nx = x + fshr(y, i); ny = y - fshr(x, i); z += atan_step(i);
      end
      x = nx; y = ny;
    end
    c = x; s = y;
  endtask

  function automatic longint to_deg16(longint a, longint lim);
    longint v;
    if (a < -64'sd2147483648) a = -64'sd2147483648;
    if (a > 64'sd2147483648) a = 64'sd2147483648;
    v = (((a + 64'sd2147483648) * 5760 + 64'sd2147483648) >>> 32) - 2880;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  // full prediction of one result beat; updates the mode bit
  task automatic predict_heading(input sample_t s);
    longint ax, ay, az, mx, my, mz, p, r, cp, sp, cr, sr, xh, yh, hd, mag, oct;
    result_t e;
    ax = s.accel_x; ay = s.accel_y; az = s.accel_z;
    mx = s.mag_x;   my = s.mag_y;   mz = s.mag_z;
    p = bin_atan2(isqrt(ay * ay + az * az) * 65536, ax * 65536);
    r = bin_atan2(isqrt(ax * ax + az * az) * 65536, ay * 65536);
    rot_sincos(p, cp, sp);
    rot_sincos(r, cr, sr);
    xh = fshr(mx * cp + mz * sp, 14);
    yh = fshr(mx * fshr(sr * sp, 30) + my * cr - mz * fshr(sr * cp, 30), 14);
    hd = to_deg16(bin_atan2(xh, yh), 2880);
    if (s.button_pressed) heading_mode_bit = ~heading_mode_bit;
    mag = hd < 0 ? -hd : hd;
    oct = (mag + 360) / 720;
    if (hd < 0) oct = -oct;
    e.heading_angle = hd[12:0];
    e.pitch_angle   = 12'(to_deg16(p, 1440));
    e.roll_angle    = 12'(to_deg16(r, 1440));
    e.led_index     = heading_mode_bit ? 3'd0 : 3'((8 - oct) & 7);
    e.led_enable    = ~heading_mode_bit;
    e.display_mode  = heading_mode_bit;
    expected_q.push_back(e);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH beat %0d %s: got %0d want %0d", beats_checked, what, got, want);
    mismatches++;
  endtask

  // send one sample beat; predictor runs at the accept edge
  task automatic send_sample(input sample_t s);
    while (!no_idle && $urandom_range(99) < 15) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predict_heading(s);
    beats_sent++;
    if (s.button_pressed) press_count++;
  endtask

  // receiver: random stalls, checks each accepted result beat
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected beat", result.heading_angle, 0);
        end else begin
          result_t e;
          e = expected_q.pop_front();
          if (result.heading_angle !== e.heading_angle)
            report_mismatch("heading", result.heading_angle, e.heading_angle);
          if (result.pitch_angle !== e.pitch_angle)
            report_mismatch("pitch", result.pitch_angle, e.pitch_angle);
          if (result.roll_angle !== e.roll_angle)
            report_mismatch("roll", result.roll_angle, e.roll_angle);
          if (result.led_index !== e.led_index)
            report_mismatch("led_index", result.led_index, e.led_index);
          if (result.led_enable !== e.led_enable)
            report_mismatch("led_enable", result.led_enable, e.led_enable);
          if (result.display_mode !== e.display_mode)
            report_mismatch("display_mode", result.display_mode, e.display_mode);
          beats_checked++;
        end
      end
      result_stall <= !no_idle && ($urandom_range(99) < 15);
    end
  end

  function automatic sample_t mk(int ax, int ay, int az, int mx, int my, int mz, bit b);
    sample_t s;
    s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
    s.mag_x = 16'(mx);   s.mag_y = 16'(my);   s.mag_z = 16'(mz);
    s.button_pressed = b;
    return s;
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s = 97'({$urandom, $urandom, $urandom, $urandom});
    s.button_pressed = ($urandom_range(9) == 0);
    return s;
  endfunction

  // level device, nose up/down, rolled, zero vectors, full-scale corners
  task automatic test_directed();
    send_sample(mk(0, 0, 0, 0, 0, 0, 0));              // atan2(0,0) everywhere
    send_sample(mk(0, 0, 16384, 16384, 0, 0, 0));      // level, north
    send_sample(mk(0, 0, 16384, 0, 16384, 0, 0));
    send_sample(mk(0, 0, 16384, -16384, 0, 0, 0));     // heading at half turn
    send_sample(mk(0, 0, 16384, 0, -16384, 0, 0));
    send_sample(mk(16384, 0, 0, 1000, 200, 3000, 0));  // vertical axis, +90 pitch
    send_sample(mk(-16384, 0, 0, 1000, 200, 3000, 0)); // -90 pitch
    send_sample(mk(0, 16384, 0, 500, -900, 100, 0));   // vertical roll
    send_sample(mk(0, -16384, 0, 500, -900, 100, 0));
    send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767, 0));
    send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, 0));
    send_sample(mk(32767, -32768, 32767, -32768, 32767, -32768, 0));
    send_sample(mk(-32768, 32767, -32768, 32767, -32768, 32767, 0));
    send_sample(mk(0, 0, -16384, 16384, 16384, 0, 0)); // upside down
    send_sample(mk(0, 0, 16384, 16384, 16384, 0, 1));  // into pitch/roll mode
    send_sample(mk(0, 0, 16384, 16384, -16384, 0, 0));
    send_sample(mk(1, -1, 1, -1, 1, -1, 1));           // back to heading mode
    send_sample(mk(0, 0, 16384, -16384, 1, 0, 0));     // near the cut at +-180
    send_sample(mk(0, 0, 16384, -16384, -1, 0, 0));
    for (int k = 0; k < 6; k++)                         // octant boundaries
      send_sample(mk(0, 0, 16384, 10000, 4142 * (k - 3), 0, 0));
  endtask

  task automatic test_random_samples(input int count);
    for (int k = 0; k < count; k++) begin
      no_idle = (k >= count / 2 && k < count / 2 + 150);
      if ($urandom_range(3) == 0)
        send_sample(rand_sample());
      else   // realistic magnitudes, random tilt
        send_sample(mk($urandom_range(8000) - 4000, $urandom_range(8000) - 4000,
                       $urandom_range(32767) - 16384, $urandom_range(4000) - 2000,
                       $urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                       $urandom_range(7) == 0));
    end
    no_idle = 1'b0;
  endtask

  task automatic drain_results();
    sample_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  initial begin
    heading_mode_bit = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_samples(1375);
    drain_results();
    $display("Checked %0d of %0d sample beats, %0d button presses, directed and random.",
             beats_checked, beats_sent, press_count);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("tilt_compensated_compass_test: done, clean");
    else
      $display("tilt_compensated_compass_test: done, errors");
    $finish;
  end

  // watchdog: ends the run with errors if the 1400 beats have not finished by 80 ms
  initial begin
    #80ms;
    $display("tilt_compensated_compass_test: done, errors");
    $finish;
  end
endmodule
